FILE: hw/rtl/depth_frame_delta_encoder_defines.svh
// ----------------------------------------------------------------------------
// depth frame delta encoder assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef DEPTH_FRAME_DELTA_ENCODER_DEFINES_SVH
`define DEPTH_FRAME_DELTA_ENCODER_DEFINES_SVH

// same-cycle implication, held off during reset
`define DFDE_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define DFDE_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: hw/rtl/dfde_pkg.sv
// ----------------------------------------------------------------------------
// dfde_pkg
// types and constants shared by the depth frame delta encoder
// ----------------------------------------------------------------------------
package dfde_pkg;

  localparam int PIX_W     = 8;
  localparam int INDEX_W   = 18;
  localparam int LEN_W     = 21;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * CFG_W;
  localparam int KIND_W    = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd2;

  localparam logic [CFG_W-1:0] DEF_ROWS = 11'd424;
  localparam logic [CFG_W-1:0] DEF_COLS = 11'd512;

  localparam logic [LEN_W-1:0] BYTES_PER_RECORD = 21'd4;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_RAW    = 2'd0,
    KIND_DELTA  = 2'd1,
    KIND_LENGTH = 2'd2
  } kind_t;

  // one pixel on its way from the accept stage to the compare stage
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [INDEX_W-1:0] pixel_index;
    logic               raw_path;
    logic               last;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [INDEX_W-1:0] pixel_index;
    logic               negative;
    logic [PIX_W-1:0]   magnitude;
    logic [PIX_W-1:0]   raw_pixel;
    logic [LEN_W-1:0]   frame_length;
    logic               frame_end;
  } result_t;

endpackage

FILE: hw/rtl/dfde_frame_store.sv
// ----------------------------------------------------------------------------
// dfde_frame_store
// previous-frame memory, one read and one write to the same entry per pixel
// ----------------------------------------------------------------------------
module dfde_frame_store import dfde_pkg::*; #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  // read-first: the old value comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/dfde_delta_unit.sv
// ----------------------------------------------------------------------------
// dfde_delta_unit
// compare stage: holds one pixel, forms raw, record and trailer results
// ----------------------------------------------------------------------------
module dfde_delta_unit import dfde_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  item_t            item_in,
  input  logic [PIX_W-1:0] old_pixel,
  input  logic             advance,
  output logic             s1_valid,
  output logic [1:0]       push_count,
  output result_t          res_first,
  output result_t          res_second
);

  item_t            item;
  logic [LEN_W-1:0] record_bytes;
  logic [LEN_W-1:0] length_now;
  logic             changed;
  logic             negative;
  logic [PIX_W-1:0] magnitude;
  logic             has_record;
  logic             has_trailer;
  result_t          raw_res;
  result_t          rec_res;
  result_t          trl_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

  always_comb begin
    changed     = item.pixel != old_pixel;
    negative    = item.pixel < old_pixel;
    magnitude   = negative ? old_pixel - item.pixel : item.pixel - old_pixel;
    has_record  = !item.raw_path && changed;
    has_trailer = !item.raw_path && item.last;
    length_now  = has_record ? record_bytes + BYTES_PER_RECORD : record_bytes;
  end

  // byte count of the delta frame in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      record_bytes <= '0;
    end else if (s1_valid && advance) begin
      if (item.last) begin
        record_bytes <= '0;
      end else begin
        record_bytes <= length_now;
      end
    end
  end

  always_comb begin
    raw_res              = '0;
    raw_res.kind         = KIND_RAW;
    raw_res.raw_pixel    = item.pixel;
    raw_res.frame_end    = item.last;

    rec_res              = '0;
    rec_res.kind         = KIND_DELTA;
    rec_res.pixel_index  = item.pixel_index;
    rec_res.negative     = negative;
    rec_res.magnitude    = magnitude;

    trl_res              = '0;
    trl_res.kind         = KIND_LENGTH;
    trl_res.frame_length = length_now;
    trl_res.frame_end    = 1'b1;

    res_second = trl_res;
    if (item.raw_path) begin
      res_first  = raw_res;
      push_count = 2'd1;
    end else if (has_record) begin
      res_first  = rec_res;
      push_count = has_trailer ? 2'd2 : 2'd1;
    end else begin
      res_first  = trl_res;
      push_count = has_trailer ? 2'd1 : 2'd0;
    end
  end

endmodule

FILE: hw/rtl/dfde_result_queue.sv
// ----------------------------------------------------------------------------
// dfde_result_queue
// small result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
module dfde_result_queue import dfde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  result_t    push_first,
  input  result_t    push_second,
  input  logic       pop,
  output logic       room,
  output logic       head_valid,
  output result_t    head
);

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  // room for the worst case of two results from one pixel
  assign room       = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign count_next = count + QCNT_W'(push_n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

FILE: hw/rtl/depth_frame_delta_encoder.sv
// ----------------------------------------------------------------------------
// depth_frame_delta_encoder
// inter-frame delta encoder for 8-bit depth pixels with a frame store
// ----------------------------------------------------------------------------
// Takes one depth pixel per clock in raster order and accepts a new pixel in
// every cycle while the result side keeps up. Each pixel costs one read and
// one write of the frame store, both on the same port in the cycle it is
// accepted (read-first), so the store limits the rate to one pixel a cycle.
// Results leave through the store read, registered alongside the pixel in
// the compare stage, and then a four-entry result queue. The last pixel of
// a delta frame may give two results (a record and the length trailer);
// the queue drains one a cycle, so such a frame end can hold the input when
// results pile up. The frame store is not cleared after reset and needs no
// start-up pass: the first delta-mode frame is sent raw and fills it. Frame
// size is rows times columns, a zero count taken as one, capped at
// MAX_PIXELS; it is worked out when a size register is written, so
// configuration changes take effect from the next pixel.
module depth_frame_delta_encoder import dfde_pkg::*; #(
  parameter int MAX_PIXELS = 262144
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // pixel stream in
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] pixel
  // result stream out
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // [17:0] pixel_index, [18] negative,
                                          // [26:19] magnitude, [34:27] raw_pixel,
                                          // [55:35] frame_length
  output logic                 m_tlast,   // frame_end
  output logic [1:0]           m_tuser    // [1:0] kind
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam logic [PROD_W-1:0] MAX_SIZE = PROD_W'(MAX_PIXELS);

  // index of the last pixel of a frame for a given size
  function automatic logic [AW-1:0] size_last_of(input logic [CFG_W-1:0] rows_in,
                                                 input logic [CFG_W-1:0] cols_in);
    logic [CFG_W-1:0]  rows_eff;
    logic [CFG_W-1:0]  cols_eff;
    logic [PROD_W-1:0] prod;
    rows_eff = (rows_in == '0) ? CFG_W'(1) : rows_in;
    cols_eff = (cols_in == '0) ? CFG_W'(1) : cols_in;
    prod     = PROD_W'(rows_eff) * PROD_W'(cols_eff);
    if (prod > MAX_SIZE) begin
      return AW'(MAX_PIXELS - 1);
    end else begin
      return AW'(prod - PROD_W'(1));
    end
  endfunction

  // configuration registers
  logic             mode;
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic [AW-1:0]    size_last;

  // accept stage state
  logic [AW-1:0]    pixel_counter;
  logic             first_frame;
  logic             in_accept;
  logic             frame_last;
  item_t            item_in;

  // between stages
  logic [PIX_W-1:0] old_pixel;
  logic             s1_valid;
  logic             room;
  logic             advance;
  logic [1:0]       push_count;
  logic [1:0]       push_n;
  result_t          res_first;
  result_t          res_second;
  logic             head_valid;
  result_t          head;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b1;
      row_count    <= DEF_ROWS;
      column_count <= DEF_COLS;
      size_last    <= size_last_of(DEF_ROWS, DEF_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: begin
          mode <= cfg_data[0];
        end
        REG_ROWS: begin
          row_count <= cfg_data;
          size_last <= size_last_of(cfg_data, column_count);
        end
        REG_COLS: begin
          column_count <= cfg_data;
          size_last    <= size_last_of(row_count, cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  // the compare stage moves on when the queue can take its worst case
  assign advance   = room;
  assign s_tready  = !s1_valid || advance;
  assign in_accept = s_tvalid && s_tready;

  // also ends the frame early if the size has shrunk below the counter
  assign frame_last = pixel_counter >= size_last;

  always_comb begin
    item_in.pixel       = s_tdata[PIX_W-1:0];
    item_in.pixel_index = INDEX_W'(pixel_counter);
    item_in.raw_path    = !mode || first_frame;
    item_in.last        = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_counter <= '0;
      first_frame   <= 1'b1;
    end else if (in_accept) begin
      pixel_counter <= frame_last ? '0 : pixel_counter + AW'(1);
      // only a frame that ends in delta mode clears the raw first frame
      if (mode && frame_last) begin
        first_frame <= 1'b0;
      end
    end
  end

  dfde_frame_store #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_frame_store (
    .clk   (clk),
    .en    (in_accept),
    .addr  (pixel_counter),
    .wdata (s_tdata[PIX_W-1:0]),
    .rdata (old_pixel)
  );

  dfde_delta_unit u_delta_unit (
    .clk        (clk),
    .rst        (rst),
    .load       (in_accept),
    .item_in    (item_in),
    .old_pixel  (old_pixel),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .push_count (push_count),
    .res_first  (res_first),
    .res_second (res_second)
  );

  assign push_n = (s1_valid && advance) ? push_count : 2'd0;
  assign pop    = m_tvalid && m_tready;

  dfde_result_queue u_result_queue (
    .clk         (clk),
    .rst         (rst),
    .push_n      (push_n),
    .push_first  (res_first),
    .push_second (res_second),
    .pop         (pop),
    .room        (room),
    .head_valid  (head_valid),
    .head        (head)
  );

  assign m_tvalid = head_valid;
  assign m_tdata  = {head.frame_length, head.raw_pixel, head.magnitude,
                     head.negative, head.pixel_index};
  assign m_tlast  = head.frame_end;
  assign m_tuser  = head.kind;

endmodule

FILE: hw/rtl/dfde_checker.sv
// ----------------------------------------------------------------------------
// dfde_checker
// port-level checks on the result stream of the delta encoder
// ----------------------------------------------------------------------------
`include "depth_frame_delta_encoder_defines.svh"

module dfde_checker import dfde_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  // raw results carry nothing but the pixel and the frame mark
  `DFDE_ASSERT_NOW(a_raw_clean, m_tvalid && (m_tuser == KIND_RAW), (m_tdata[26:0] == '0) && (m_tdata[55:35] == '0), "raw result with delta fields set")

  // a trailer closes the frame and counts whole four-byte records
  `DFDE_ASSERT_NOW(a_trailer_shape, m_tvalid && (m_tuser == KIND_LENGTH), m_tlast && (m_tdata[36:35] == 2'b00), "bad length trailer")

  // a record exists only for a real change and never ends a frame
  `DFDE_ASSERT_NOW(a_record_shape, m_tvalid && (m_tuser == KIND_DELTA), !m_tlast && (m_tdata[26:19] != '0), "bad delta record")

  // a stalled transaction holds its payload
  `DFDE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed while stalled")

endmodule

bind depth_frame_delta_encoder dfde_checker u_checker (.*);

FILE: dv/depth_frame_delta_encoder_tb.sv
// ----------------------------------------------------------------------------
// depth_frame_delta_encoder_tb
// self-checking bench for the depth frame delta encoder
// ----------------------------------------------------------------------------
// A queue of pixels, filled phase by phase by the stimulus process, feeds a
// clocked stream driver. Each accepted pixel runs through a bench-side copy of
// the encoder (frame store, first-frame flag, pixel position, record byte
// count), and the results it gives wait in order. A clocked monitor takes each
// result transaction and compares every field with the oldest waiting one.
// Registers change only while the encoder is idle. A directed opening covers
// the special cases, then a pass-through burst meets a long receiver stall;
// random phases follow, then a few pixels at large register values,
// which must not end a frame.
// ----------------------------------------------------------------------------
module depth_frame_delta_encoder_tb import dfde_pkg::*; ();

  localparam int unsigned MAX_PIXELS   = 262144;
  localparam int unsigned WATCHDOG_MAX = 2000;  // cycles with no transaction
  localparam int unsigned SETTLE       = 8;     // pipeline plus queue, with margin
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned CALM_FROM    = 200;   // no idling in this window
  localparam int unsigned CALM_TO      = 320;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;   // [7:0] pixel
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [55:0]       m_tdata;          // [17:0] pixel_index, [18] negative,
                                       // [26:19] magnitude, [34:27] raw_pixel,
                                       // [55:35] frame_length
  logic              m_tlast;          // frame_end
  logic [1:0]        m_tuser;          // [1:0] kind

  depth_frame_delta_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register copies, written only by the stimulus process while idle
  logic              cfg_mode = 1'b1;
  logic [CFG_W-1:0]  cfg_rows = DEF_ROWS;
  logic [CFG_W-1:0]  cfg_cols = DEF_COLS;

  // bench-side encoder state, advanced on every accepted pixel
  logic [7:0]        prev_frame [0:MAX_PIXELS-1];
  logic              enc_first = 1'b1;
  int unsigned       enc_pos   = 0;
  logic [LEN_W-1:0]  enc_bytes = '0;

  // pixels waiting for the driver, and results waiting for the monitor
  logic [7:0]        pending_pixels [$];
  result_t           expected_results [$];

  // planning copy of the frame position, so that the stimulus never makes the
  // encoder compare against a store entry that was never written
  int unsigned       plan_pos    = 0;
  int unsigned       plan_stored = 0;  // entries 0 .. plan_stored-1 are written
  logic              plan_first  = 1'b1;
  logic [7:0]        scene [int];      // last value planned for each index

  int unsigned       pixels_accepted = 0;
  int unsigned       results_seen    = 0;
  int unsigned       raw_seen        = 0;
  int unsigned       delta_seen      = 0;
  int unsigned       trailer_seen    = 0;
  int unsigned       mismatches      = 0;
  int unsigned       phases          = 0;
  int unsigned       quiet_cycles    = 0;
  int unsigned       hold_left       = 0;
  logic              hold_done       = 1'b0;
  logic              hold_request    = 1'b0;  // set by the stimulus before a burst

  // rows times columns, zero taken as one, capped at the store size
  function automatic int unsigned frame_pixels(logic [CFG_W-1:0] rows,
                                               logic [CFG_W-1:0] cols);
    int unsigned r;
    int unsigned c;
    r = (rows == 0) ? 1 : rows;
    c = (cols == 0) ? 1 : cols;
    return (r * c > MAX_PIXELS) ? MAX_PIXELS : r * c;
  endfunction

  // work out the results of one accepted pixel
  task automatic encode_pixel(input logic [7:0] px);
    int unsigned size;
    logic        last;
    logic [7:0]  old;
    result_t     r;
    size = frame_pixels(cfg_rows, cfg_cols);
    last = (enc_pos + 1 >= size);
    r = '0;
    if (!cfg_mode || enc_first) begin
      // pass-through, or the first delta-mode frame: raw copy
      r.kind      = KIND_RAW;
      r.raw_pixel = px;
      r.frame_end = last;
      expected_results.push_back(r);
      if (cfg_mode && last) begin
        enc_first = 1'b0;
      end
    end else begin
      old = prev_frame[enc_pos];
      if (px != old) begin
        r.kind        = KIND_DELTA;
        r.pixel_index = enc_pos[INDEX_W-1:0];
        r.negative    = (px < old);
        r.magnitude   = (px < old) ? old - px : px - old;
        expected_results.push_back(r);
        enc_bytes = enc_bytes + BYTES_PER_RECORD;
      end
      if (last) begin
        // trailer follows the records of the frame
        r = '0;
        r.kind         = KIND_LENGTH;
        r.frame_length = enc_bytes;
        r.frame_end    = 1'b1;
        expected_results.push_back(r);
      end
    end
    prev_frame[enc_pos] = px;
    if (last) begin
      enc_pos   = 0;
      enc_bytes = '0;
    end else begin
      enc_pos = enc_pos + 1;
    end
  endtask

  // ------------------------------------------------------------------------
  // pixel driver: holds tvalid and tdata until the transaction completes
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_pixel(s_tdata);
        pixels_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_pixels.size() > 0 &&
            ((pixels_accepted >= CALM_FROM && pixels_accepted < CALM_TO) ||
             $urandom_range(99) >= 11)) begin
          s_tdata  <= pending_pixels.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (m_tuser == KIND_RAW) begin
      raw_seen++;
    end else if (m_tuser == KIND_DELTA) begin
      delta_seen++;
    end else begin
      trailer_seen++;
    end
    if (expected_results.size() == 0) begin
      $error("result transaction with nothing expected: kind %0d", m_tuser);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      compare_field("kind",         want.kind,         m_tuser);
      compare_field("pixel_index",  want.pixel_index,  m_tdata[17:0]);
      compare_field("negative",     want.negative,     m_tdata[18]);
      compare_field("magnitude",    want.magnitude,    m_tdata[26:19]);
      compare_field("raw_pixel",    want.raw_pixel,    m_tdata[34:27]);
      compare_field("frame_length", want.frame_length, m_tdata[55:35]);
      compare_field("frame_end",    want.frame_end,    m_tlast);
    end
  endtask

  // ------------------------------------------------------------------------
  // result monitor and receiver back-pressure; one long stall during a
  // pass-through burst lets the encoder fill up and hold its input
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result();
      end
      if (!hold_done && hold_request) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (results_seen >= CALM_FROM && results_seen < CALM_TO) ||
                    ($urandom_range(99) >= 11);
      end
    end
  end

  // watchdog on transactions of either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // sender pause: everything sent, every result back, pipeline drained
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (!(pending_pixels.size() == 0 && !s_tvalid &&
                 expected_results.size() == 0));
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic configure(input logic mode, input logic [CFG_W-1:0] rows,
                           input logic [CFG_W-1:0] cols);
    wait_idle();
    write_reg(REG_MODE, CFG_W'(mode));
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_mode = mode;
    cfg_rows = rows;
    cfg_cols = cols;
    phases++;
    @(negedge clk);
  endtask

  // queue one pixel and advance the planning position
  task automatic queue_pixel(input logic [7:0] px);
    logic last;
    last = (plan_pos + 1 >= frame_pixels(cfg_rows, cfg_cols));
    pending_pixels.push_back(px);
    scene[plan_pos] = px;
    if (plan_pos + 1 > plan_stored) begin
      plan_stored = plan_pos + 1;
    end
    if (cfg_mode && last) begin
      plan_first = 1'b0;
    end
    plan_pos = last ? 0 : plan_pos + 1;
  endtask

  // mostly a static scene with changes here and there, extremes now and then
  function automatic logic [7:0] pick_pixel();
    if (scene.exists(plan_pos) && $urandom_range(1) == 1) begin
      return scene[plan_pos];
    end
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned      n;
    int unsigned      random_pixels;
    logic             mode;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    random_pixels = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: delta mode, large frame, so a raw pixel with no frame end
    queue_pixel(8'hA5);
    // pass-through finishes that frame and leaves the first-frame flag set
    configure(1'b0, 11'd1, 11'd3);
    queue_pixel(8'h00);
    queue_pixel(8'hFF);
    // first delta-mode frame is sent raw and fills the store
    configure(1'b1, 11'd2, 11'd2);
    queue_pixel(8'd0);
    queue_pixel(8'd255);
    queue_pixel(8'd10);
    queue_pixel(8'd200);
    // full-scale rise and fall, an unchanged pixel, a step of one
    queue_pixel(8'd255);
    queue_pixel(8'd0);
    queue_pixel(8'd10);
    queue_pixel(8'd201);
    // nothing changes: trailer alone with length zero
    queue_pixel(8'd255);
    queue_pixel(8'd0);
    queue_pixel(8'd10);
    queue_pixel(8'd201);
    // zero row count taken as one row
    configure(1'b1, 11'd0, 11'd4);
    queue_pixel(8'd254);
    queue_pixel(8'd0);
    queue_pixel(8'd11);
    queue_pixel(8'd201);
    queue_pixel(8'd1);
    queue_pixel(8'd2);
    // frame shrinks under the position: next pixel ends the frame
    configure(1'b1, 11'd1, 11'd1);
    queue_pixel(8'd3);
    // records, then pass-through ends the frame without a trailer
    configure(1'b1, 11'd2, 11'd2);
    queue_pixel(8'd7);
    queue_pixel(8'd9);
    configure(1'b0, 11'd2, 11'd2);
    queue_pixel(8'd10);
    queue_pixel(8'd201);
    queue_pixel(8'd1);
    queue_pixel(8'd2);
    // back to delta mid-frame: only the later pixels give records
    configure(1'b1, 11'd2, 11'd2);
    queue_pixel(8'd3);
    queue_pixel(8'd4);

    // pass-through burst while the receiver holds off: the encoder fills up
    configure(1'b0, 11'd4, 11'd8);
    hold_request = 1'b1;
    repeat (32) queue_pixel(8'($urandom_range(255)));

    // random phases of small frames
    while (random_pixels < 400) begin
      mode = ($urandom_range(3) != 0);
      rows = ($urandom_range(9) == 0) ? 11'd0 : CFG_W'($urandom_range(1, 4));
      case ($urandom_range(9))
        0:       cols = 11'd0;
        1:       cols = CFG_W'($urandom_range(9, 40));
        default: cols = CFG_W'($urandom_range(1, 8));
      endcase
      // a frame reaching past the written part of the store goes through
      // pass-through until the store covers it
      if (mode && !plan_first &&
          (frame_pixels(rows, cols) > plan_stored || plan_pos >= plan_stored)) begin
        mode = 1'b0;
      end
      configure(mode, rows, cols);
      n = $urandom_range(5, 60);
      repeat (n) queue_pixel(pick_pixel());
      random_pixels += n;
    end

    // large register values: the capped frame is far from its end
    configure(1'b0, 11'd1024, 11'd1024);
    repeat (16) queue_pixel(8'($urandom_range(255)));

    wait_idle();
    repeat (2 * SETTLE) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    $display("covered %0d pixels over %0d register settings, one long receiver stall",
             pixels_accepted, phases);
    $display("checked %0d results: %0d raw, %0d delta records, %0d length trailers",
             results_seen, raw_seen, delta_seen, trailer_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
